/* rtl/core/sidc_pkg.sv */
// Package for the SIMT instruction decoder: pattern table, format and
// operation codes, and the decode result type shared by the core modules.
// No dependencies.
`timescale 1ns / 1ps

package sidc_pkg;

   localparam int NUM_ENTRIES = 21;
   localparam int OP_WIDTH    = 5;
   localparam int FMT_WIDTH   = 4;
   localparam int REG_WIDTH   = 5;
   localparam int WORD_WIDTH  = 32;

   localparam logic [FMT_WIDTH-1:0] FMT_R   = 4'd0;
   localparam logic [FMT_WIDTH-1:0] FMT_I   = 4'd1;
   localparam logic [FMT_WIDTH-1:0] FMT_U   = 4'd2;
   localparam logic [FMT_WIDTH-1:0] FMT_S   = 4'd3;
   localparam logic [FMT_WIDTH-1:0] FMT_J   = 4'd4;
   localparam logic [FMT_WIDTH-1:0] FMT_B   = 4'd5;
   localparam logic [FMT_WIDTH-1:0] FMT_CSR = 4'd6;
   localparam logic [FMT_WIDTH-1:0] FMT_FR  = 4'd7;
   localparam logic [FMT_WIDTH-1:0] FMT_FI  = 4'd8;
   localparam logic [FMT_WIDTH-1:0] FMT_FS  = 4'd9;
   localparam logic [FMT_WIDTH-1:0] FMT_F4  = 4'd10;

   localparam logic [OP_WIDTH-1:0] OP_EBREAK = 5'd7;

   localparam logic [WORD_WIDTH-1:0] PAT_MASK [NUM_ENTRIES] = '{
      32'hFE00707F, 32'h0000707F, 32'hFE00707F, 32'h0000707F, 32'h0000007F,
      32'h0000707F, 32'h0000707F, 32'hFFFFFFFF, 32'hFE00007F, 32'hFE00007F,
      32'hFFF0007F, 32'hFFF0007F, 32'hFFF0007F, 32'hFFF0007F, 32'hFFF0007F,
      32'hFFF0007F, 32'hFFF0007F, 32'hFFF0007F, 32'hFFF0007F, 32'hFFF0007F,
      32'hFFF0707F
   };

   localparam logic [WORD_WIDTH-1:0] PAT_MATCH [NUM_ENTRIES] = '{
      32'h00000033, 32'h00000013, 32'h00001013, 32'h00007013, 32'h00000037,
      32'h00002023, 32'h00002073, 32'h00100073, 32'h00000053, 32'h10000053,
      32'hD0000053, 32'hC0000053, 32'h44000053, 32'h44100053, 32'h48000053,
      32'h48100053, 32'h48200053, 32'h48300053, 32'h4C000053, 32'h4C100053,
      32'hF0000053
   };

   localparam logic [FMT_WIDTH-1:0] PAT_FMT [NUM_ENTRIES] = '{
      FMT_R,  FMT_I,  FMT_I,  FMT_I,  FMT_U,
      FMT_S,  FMT_CSR, FMT_I, FMT_FR, FMT_FR,
      FMT_FI, FMT_FI, FMT_FR, FMT_FR, FMT_FR,
      FMT_FR, FMT_FR, FMT_FR, FMT_FR, FMT_FR,
      FMT_FI
   };

   typedef struct packed {
      logic                 supported;
      logic [OP_WIDTH-1:0]  operation;
      logic [FMT_WIDTH-1:0] format_type;
   } dec_result_type;

endpackage

/* rtl/core/sidc_match.sv */
// Pattern matcher: compares the word against every table entry in parallel
// and picks the lowest-numbered hit. Depends on sidc_pkg.
`timescale 1ns / 1ps

module sidc_match
   import sidc_pkg::*;
(
   input  logic [WORD_WIDTH-1:0] word,
   output dec_result_type        result
);

   logic [NUM_ENTRIES-1:0] hit;

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         hit[i] = (word & PAT_MASK[i]) == PAT_MATCH[i];
      end
   end

   // priority: walk down so the lowest index is written last
   always_comb begin
      result = '0;
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            result.supported   = 1'b1;
            result.operation   = OP_WIDTH'(i);
            result.format_type = PAT_FMT[i];
         end
      end
   end

endmodule

/* rtl/core/sidc_imm.sv */
// Immediate builder: forms the immediate from the word by format type.
// Depends on sidc_pkg.
`timescale 1ns / 1ps

module sidc_imm
   import sidc_pkg::*;
(
   input  logic [WORD_WIDTH-1:0] word,
   input  logic [FMT_WIDTH-1:0]  format_type,
   output logic [WORD_WIDTH-1:0] imm
);

   always_comb begin
      case (format_type)
         FMT_I, FMT_FI: begin
            imm = {{20{word[31]}}, word[31:20]};
         end
         FMT_S, FMT_FS: begin
            imm = {{20{word[31]}}, word[31:25], word[11:7]};
         end
         FMT_U: begin
            imm = {word[31:12], 12'b0};
         end
         FMT_B: begin
            imm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
         end
         FMT_J: begin
            imm = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
         end
         FMT_CSR: begin
            imm = {20'b0, word[31:20]};
         end
         default: begin
            imm = '0;
         end
      endcase
   end

endmodule

/* rtl/core/simt_instruction_decoder_core.sv */
// Top level of the SIMT instruction decoder: input register, decode logic,
// result register. Depends on sidc_pkg, sidc_match and sidc_imm.
`timescale 1ns / 1ps

// Decodes one 32-bit instruction word per transaction against a fixed table
// of 21 mask/match patterns (RV32I subset, RV32F add/multiply/conversions and
// custom low-precision float conversions); the lowest-numbered match wins.
// One transaction is accepted every cycle while req_stall is low. The word sits
// in the input register while the parallel pattern compare and immediate mux
// run, then the result register loads and rsp_valid rises with it.
// An unmatched word returns supported low and every other field zero.
// req_stall rises only when both registers are full and rsp_stall is high.

module simt_instruction_decoder_core
   import sidc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [WORD_WIDTH-1:0]       req_instruction,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_supported,
   output logic [OP_WIDTH-1:0]         rsp_operation,
   output logic [FMT_WIDTH-1:0]        rsp_format_type,
   output logic [REG_WIDTH-1:0]        rsp_dest_reg,
   output logic [REG_WIDTH-1:0]        rsp_src_reg_one,
   output logic [REG_WIDTH-1:0]        rsp_src_reg_two,
   output logic [REG_WIDTH-1:0]        rsp_src_reg_three,
   output logic signed [WORD_WIDTH-1:0] rsp_immediate,
   output logic                        rsp_halt
);

   logic                  in_valid_ff, in_valid_in;
   logic [WORD_WIDTH-1:0] in_word_ff;
   logic                  out_valid_ff, out_valid_in;
   dec_result_type        out_dec_ff;
   logic [WORD_WIDTH-1:0] out_word_ff;
   logic [WORD_WIDTH-1:0] out_imm_ff;
   logic                  out_halt_ff;

   dec_result_type        dec;
   logic [WORD_WIDTH-1:0] imm;
   logic                  out_load;
   logic                  in_load;

   sidc_match u_match (
      .word   (in_word_ff),
      .result (dec)
   );

   sidc_imm u_imm (
      .word        (in_word_ff),
      .format_type (dec.format_type),
      .imm         (imm)
   );

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_word_ff <= req_instruction;
      end
      if (out_load && in_valid_ff) begin
         out_dec_ff  <= dec;
         out_word_ff <= dec.supported ? in_word_ff : '0;
         out_imm_ff  <= dec.supported ? imm : '0;
         out_halt_ff <= dec.supported && (dec.operation == OP_EBREAK);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_supported     = out_dec_ff.supported;
   assign rsp_operation     = out_dec_ff.operation;
   assign rsp_format_type   = out_dec_ff.format_type;
   assign rsp_dest_reg      = out_word_ff[11:7];
   assign rsp_src_reg_one   = out_word_ff[19:15];
   assign rsp_src_reg_two   = out_word_ff[24:20];
   assign rsp_src_reg_three = out_word_ff[31:27];
   assign rsp_immediate     = out_imm_ff;
   assign rsp_halt          = out_halt_ff;

   a_halt_is_ebreak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halt |-> rsp_supported && rsp_operation == OP_EBREAK)
      else $error("halt without ebreak");

   a_unmatched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_supported |->
         rsp_operation == '0 && rsp_format_type == '0 && rsp_immediate == '0
         && rsp_dest_reg == '0 && !rsp_halt)
      else $error("unmatched result not zeroed");

   a_reg_fmt_no_imm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_format_type == FMT_R || rsp_format_type == FMT_FR)
         |-> rsp_immediate == '0)
      else $error("register format with immediate");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !(out_valid_ff && rsp_stall) |=> out_valid_ff)
      else $error("decoded transaction lost between stages");

endmodule
